### rtl/adpc_pkg.sv
// ----------------------------------------------------------------------------
// adpc_pkg
// Shared types and constants for the antialiased disc coverage pipeline.
// ----------------------------------------------------------------------------
package adpc_pkg;

  localparam int PIX_W    = 6;              // pixel column / row
  localparam int SUB_BITS = 4;              // sixteenths of a pixel
  localparam int POS_W    = PIX_W + SUB_BITS;
  localparam int CRD_W    = 12;             // disc centre
  localparam int DIFF_W   = CRD_W + 1;      // signed centre offset
  localparam int MAG_W    = CRD_W;          // |offset|
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 1;
  localparam int RAD_W    = SUM_W + 1;      // radicand, even number of bits
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int RADIUS_W = 10;
  localparam int COLOR_W  = 24;
  localparam int FA_W     = 9;
  localparam int ALPHA_W  = 8;
  localparam int MARG_W   = ROOT_W + 2;
  localparam int CLAMP_W  = SUB_BITS + 1;
  localparam int PROD_W   = CLAMP_W + FA_W - 1;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [SUB_BITS-1:0] SUB_HALF  = SUB_BITS'(1 << (SUB_BITS - 1));
  localparam logic [CLAMP_W-1:0]  SUB_STEP  = CLAMP_W'(1 << SUB_BITS);
  localparam logic [FA_W-1:0]     ALPHA_ONE = FA_W'(256);
  localparam logic [ALPHA_W-1:0]  ALPHA_MAX = '1;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_DRAW_COLOR = 3'd3,
    REG_FILL_ALPHA = 3'd4,
    REG_BLEND_MODE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CRD_W-1:0]    center_x;
    logic [CRD_W-1:0]    center_y;
    logic [RADIUS_W-1:0] radius;
    logic [COLOR_W-1:0]  draw_color;
    logic [FA_W-1:0]     fill_alpha;
    logic                blend_mode;
  } cfg_t;

  // one square-root step in flight
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    logic [RAD_W-1:0]  rad;
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
  } sqc_t;

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic [ALPHA_W-1:0] alpha;
    logic               draw_enable;
  } res_t;

endpackage

### rtl/adpc_stream_if.sv
// ----------------------------------------------------------------------------
// adpc_stream_if
// Pixel request and coverage result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface adpc_pix_if
  import adpc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface adpc_res_if
  import adpc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   out_x;
  logic [PIX_W-1:0]   out_y;
  logic [COLOR_W-1:0] out_color;
  logic [ALPHA_W-1:0] out_alpha;
  logic               draw_enable;

  modport source (output valid, output out_x, output out_y, output out_color,
                  output out_alpha, output draw_enable, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_color,
                  input out_alpha, input draw_enable, output ready);
endinterface

### rtl/adpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// adpc_cfg_regs
// APB register file holding the disc geometry, colour and blend settings.
// ----------------------------------------------------------------------------
module adpc_cfg_regs
  import adpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_CENTER_X:   cfg_nxt.center_x   = pwdata[CRD_W-1:0];
        REG_CENTER_Y:   cfg_nxt.center_y   = pwdata[CRD_W-1:0];
        REG_RADIUS:     cfg_nxt.radius     = pwdata[RADIUS_W-1:0];
        REG_DRAW_COLOR: cfg_nxt.draw_color = pwdata[COLOR_W-1:0];
        REG_FILL_ALPHA: cfg_nxt.fill_alpha = pwdata[FA_W-1:0];
        REG_BLEND_MODE: cfg_nxt.blend_mode = pwdata[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X:   prdata = DATA_W'(cfg_r.center_x);
      REG_CENTER_Y:   prdata = DATA_W'(cfg_r.center_y);
      REG_RADIUS:     prdata = DATA_W'(cfg_r.radius);
      REG_DRAW_COLOR: prdata = DATA_W'(cfg_r.draw_color);
      REG_FILL_ALPHA: prdata = DATA_W'(cfg_r.fill_alpha);
      REG_BLEND_MODE: prdata = DATA_W'(cfg_r.blend_mode);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= CRD_W'(512);
      cfg_r.center_y   <= CRD_W'(512);
      cfg_r.radius     <= '0;
      cfg_r.draw_color <= '0;
      cfg_r.fill_alpha <= ALPHA_ONE;
      cfg_r.blend_mode <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/adpc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// adpc_sqrt_cell
// One restoring square-root step: retires one root bit, passes the pixel on.
// ----------------------------------------------------------------------------
module adpc_sqrt_cell
  import adpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic valid_i,
  input  sqc_t data_i,
  output logic valid_o,
  output sqc_t data_o
);

  logic             valid_r;
  sqc_t             data_r;
  sqc_t             data_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    rem_sh   = {data_i.rem[REM_W-3:0], data_i.rad[RAD_W-1 -: 2]};
    trial    = {data_i.root, 2'b01};
    ge       = rem_sh >= trial;
    data_nxt = data_i;
    data_nxt.rad  = {data_i.rad[RAD_W-3:0], 2'b00};
    data_nxt.root = {data_i.root[ROOT_W-2:0], ge};
    data_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### rtl/adpc_out_skid.sv
// ----------------------------------------------------------------------------
// adpc_out_skid
// Result register with a skid entry; stalls the pipe only when both are full.
// ----------------------------------------------------------------------------
module adpc_out_skid
  import adpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t data_i,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_v_r;
  logic out_v_nxt;
  logic skid_v_r;
  logic skid_v_nxt;
  res_t out_r;
  res_t skid_r;
  logic take;
  logic load_out;
  logic load_skid;
  logic from_skid;

  assign take = out_v_r && out_ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    from_skid  = 1'b0;
    if (skid_v_r) begin
      if (take) begin
        load_out   = 1'b1;
        from_skid  = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || take) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= from_skid ? skid_r : data_i;
    end
    if (load_skid) begin
      skid_r <= data_i;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### rtl/antialiased_disc_pixel_coverage.sv
// ----------------------------------------------------------------------------
// antialiased_disc_pixel_coverage
// Antialiased coverage and draw decision of one panel pixel against a disc.
// ----------------------------------------------------------------------------
// Pixel requests enter on in_pix (valid/ready), one result per request leaves
// on out_res in request order. Disc centre, radius, colour, opacity and mode
// are set over the APB port (cfg_*); the user must set them only while no
// request is in flight; the block does not enforce it. Stages: offset, square,
// sum, 13 square-root cells (one root bit each), the coverage and output stage.
// Throughput: one request per cycle, set by the cell chain, while not stalled.
// The output has a skid entry: while the receiver stalls, the pipe keeps
// moving until that entry fills; then in_pix.ready drops (a registered
// signal) and every stage holds. No request is dropped or repeated.
// Reset (rst_n low at a clock edge) empties the pipe and loads the register
// defaults: centre 512/512, radius 0, colour 0, opacity 256, blend mode.
// ----------------------------------------------------------------------------
module antialiased_disc_pixel_coverage
  import adpc_pkg::*;
#(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  adpc_pix_if.sink          in_pix,
  adpc_res_if.source        out_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int            LIM_W = 9;
  localparam logic [LIM_W-1:0] PW = LIM_W'(PANEL_WIDTH);
  localparam logic [LIM_W-1:0] PH = LIM_W'(PANEL_HEIGHT);

  cfg_t cfg;
  logic go;
  logic full;
  logic take_in;

  adpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign go           = !full;
  assign in_pix.ready = go;
  assign take_in      = in_pix.valid && go;

  // offset from the disc centre
  logic [POS_W-1:0]         pos_x;
  logic [POS_W-1:0]         pos_y;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [MAG_W-1:0]         adx_nxt;
  logic [MAG_W-1:0]         ady_nxt;

  always_comb begin
    pos_x   = {in_pix.pixel_x, SUB_HALF};
    pos_y   = {in_pix.pixel_y, SUB_HALF};
    dx      = $signed({{(DIFF_W-POS_W){1'b0}}, pos_x})
            - $signed({cfg.center_x[CRD_W-1], cfg.center_x});
    dy      = $signed({{(DIFF_W-POS_W){1'b0}}, pos_y})
            - $signed({cfg.center_y[CRD_W-1], cfg.center_y});
    adx_nxt = dx[DIFF_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    ady_nxt = dy[DIFF_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
  end

  logic             v0_r, v1_r, v2_r;
  logic [MAG_W-1:0] adx_r, ady_r;
  logic [PIX_W-1:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r;
  logic [SQ_W-1:0]  sqx_nxt, sqy_nxt;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;

  assign sqx_nxt = adx_r * adx_r;
  assign sqy_nxt = ady_r * ady_r;
  assign sum_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (go) begin
      v0_r <= take_in;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      adx_r <= adx_nxt;
      ady_r <= ady_nxt;
      x0_r  <= in_pix.pixel_x;
      y0_r  <= in_pix.pixel_y;
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      sum_r <= sum_nxt;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
    end
  end

  // square-root cell chain
  sqc_t cell_d [0:ROOT_W];
  logic cell_v [0:ROOT_W];

  assign cell_d[0].root = '0;
  assign cell_d[0].rem  = '0;
  assign cell_d[0].rad  = {1'b0, sum_r};
  assign cell_d[0].x    = x2_r;
  assign cell_d[0].y    = y2_r;
  assign cell_v[0]      = v2_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    adpc_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (go),
      .valid_i (cell_v[i]),
      .data_i  (cell_d[i]),
      .valid_o (cell_v[i+1]),
      .data_o  (cell_d[i+1])
    );
  end

  // coverage and draw decision
  sqc_t                     tail;
  logic signed [MARG_W-1:0] margin;
  logic [CLAMP_W-1:0]       mcl;
  logic [FA_W-1:0]          fa;
  logic [PROD_W-1:0]        prod;
  logic [FA_W-1:0]          alpha;
  logic                     on_panel;
  res_t                     res;

  always_comb begin
    tail   = cell_d[ROOT_W];
    margin = $signed({{(MARG_W-RADIUS_W){1'b0}}, cfg.radius})
           - $signed({{(MARG_W-ROOT_W){1'b0}}, tail.root})
           + $signed(MARG_W'(SUB_HALF));
    if (margin[MARG_W-1]) begin
      mcl = '0;
    end else if (margin > $signed(MARG_W'(SUB_STEP))) begin
      mcl = SUB_STEP;
    end else begin
      mcl = margin[CLAMP_W-1:0];
    end
    fa       = (cfg.fill_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.fill_alpha;
    prod     = PROD_W'(mcl) * PROD_W'(fa);
    alpha    = prod[PROD_W-1:SUB_BITS];
    on_panel = ({{(LIM_W-PIX_W){1'b0}}, tail.x} < PW)
            && ({{(LIM_W-PIX_W){1'b0}}, tail.y} < PH);

    res.x           = tail.x;
    res.y           = tail.y;
    res.color       = cfg.draw_color;
    res.alpha       = '0;
    res.draw_enable = 1'b0;
    if (on_panel) begin
      if (cfg.blend_mode) begin
        if (alpha != '0) begin
          res.draw_enable = 1'b1;
          res.alpha       = alpha[FA_W-1] ? ALPHA_MAX : alpha[ALPHA_W-1:0];
        end
      end else if (alpha[FA_W-1] || alpha[FA_W-2]) begin
        res.draw_enable = 1'b1;
        res.alpha       = ALPHA_MAX;
      end
    end
  end

  res_t out_d;

  adpc_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go && cell_v[ROOT_W]),
    .data_i    (res),
    .full      (full),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_data  (out_d)
  );

  assign out_res.out_x       = out_d.x;
  assign out_res.out_y       = out_d.y;
  assign out_res.out_color   = out_d.color;
  assign out_res.out_alpha   = out_d.alpha;
  assign out_res.draw_enable = out_d.draw_enable;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> out_res.valid)
    else $error("skid entry held without a pending result");

  a_idle_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.draw_enable |-> out_res.out_alpha == '0)
    else $error("non-zero alpha on a pixel that is not drawn");

  a_threshold_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.draw_enable && !cfg.blend_mode
      |-> out_res.out_alpha == ALPHA_MAX)
    else $error("threshold mode result is not opaque");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for antialiased_disc_pixel_coverage.
// Pixel requests are streamed in while results are taken out, both sides
// idling in random bursts. Every result is checked field by field against
// an in-bench coverage predictor or a typed table row, in request order. The
// disc is reprogrammed over APB between phases, only once the pipe has drained.
// A short directed table comes first, then randomised phases.
// ----------------------------------------------------------------------------
module tb;
  import adpc_pkg::*;

  typedef struct {
    bit                is_cfg;
    reg_idx_t          idx;
    logic [DATA_W-1:0] val;
    bit                typed;
    res_t              want;
  } dir_row_t;

  localparam int N_PHASES  = 14;
  localparam int PHASE_LEN = 100;
  localparam int TAIL_WAIT = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  adpc_pix_if pix_if ();
  adpc_res_if res_if ();

  cfg_t     disc_cfg;
  res_t     coverage_due[$];
  dir_row_t dir_tab[$];
  bit       quiet = 1'b0;
  int       src_gap_pct = 25;
  int       sink_gap_pct = 25;
  int       stall_left = 0;
  int       n_errors = 0;
  int       n_items = 0;
  int       n_drawn = 0;
  int       n_partial = 0;
  int       n_settings = 1;

  antialiased_disc_pixel_coverage u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (pix_if),
    .out_res     (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // coverage of one pixel against the programmed disc
  function automatic res_t disc_coverage(input logic [PIX_W-1:0] px,
                                         input logic [PIX_W-1:0] py);
    longint          step, dx, dy, margin;
    longint unsigned n, root, bitv;
    int unsigned     fa, cov, alpha;
    res_t            r;
    step = longint'(1) << SUB_BITS;
    dx = longint'(px) * step + step / 2 - longint'($signed(disc_cfg.center_x));
    dy = longint'(py) * step + step / 2 - longint'($signed(disc_cfg.center_y));
    n = longint'(dx * dx + dy * dy);
    root = 0;
    bitv = 64'h1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    margin = longint'(disc_cfg.radius) - longint'(root) + step / 2;
    if (margin < 0) margin = 0;
    if (margin > step) margin = step;
    cov = int'((margin * 256) >> SUB_BITS);
    fa = (disc_cfg.fill_alpha > 256) ? 256 : int'(disc_cfg.fill_alpha);
    alpha = (cov * fa) >> 8;
    r.x = px;
    r.y = py;
    r.color = disc_cfg.draw_color;
    r.alpha = '0;
    r.draw_enable = 1'b0;
    if (disc_cfg.blend_mode) begin
      if (alpha > 0) begin
        r.draw_enable = 1'b1;
        r.alpha = (alpha > 255) ? ALPHA_MAX : alpha[ALPHA_W-1:0];
      end
    end else if (alpha >= 128) begin
      r.draw_enable = 1'b1;
      r.alpha = ALPHA_MAX;
    end
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t pix_row(input int px, input int py);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_CENTER_X;
    r.val = '0;
    r.typed = 1'b0;
    r.want = '0;
    r.want.x = px[PIX_W-1:0];
    r.want.y = py[PIX_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t hit_row(input int px, input int py, input int color,
                                       input int alpha, input bit en);
    dir_row_t r;
    r = pix_row(px, py);
    r.typed = 1'b1;
    r.want.color = color[COLOR_W-1:0];
    r.want.alpha = alpha[ALPHA_W-1:0];
    r.want.draw_enable = en;
    return r;
  endfunction

  task automatic send_pixel(input dir_row_t row);
    int gap;
    if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 5);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid   <= 1'b1;
    pix_if.pixel_x <= row.want.x;
    pix_if.pixel_y <= row.want.y;
    do @(posedge clk); while (!pix_if.ready);
    coverage_due.push_back(row.typed ? row.want : disc_coverage(row.want.x, row.want.y));
    n_items++;
  endtask

  // only with the pipe empty
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    pix_if.valid <= 1'b0;
    while (coverage_due.size() != 0) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_X:   disc_cfg.center_x   = val[CRD_W-1:0];
      REG_CENTER_Y:   disc_cfg.center_y   = val[CRD_W-1:0];
      REG_RADIUS:     disc_cfg.radius     = val[RADIUS_W-1:0];
      REG_DRAW_COLOR: disc_cfg.draw_color = val[COLOR_W-1:0];
      REG_FILL_ALPHA: disc_cfg.fill_alpha = val[FA_W-1:0];
      REG_BLEND_MODE: disc_cfg.blend_mode = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < sink_gap_pct) begin
      res_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_res
    res_t got, want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.x = res_if.out_x;
      got.y = res_if.out_y;
      got.color = res_if.out_color;
      got.alpha = res_if.out_alpha;
      got.draw_enable = res_if.draw_enable;
      if (coverage_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result at pixel (%0d,%0d)", got.x, got.y);
      end else begin
        want = coverage_due.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
            got.alpha !== want.alpha || got.draw_enable !== want.draw_enable) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected (%0d,%0d) color %06h alpha %0d en %0b, got (%0d,%0d) color %06h alpha %0d en %0b",
                     want.x, want.y, want.color, want.alpha, want.draw_enable,
                     got.x, got.y, got.color, got.alpha, got.draw_enable);
        end
        if (got.draw_enable) n_drawn++;
        if (got.alpha != 0 && got.alpha != ALPHA_MAX) n_partial++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("antialiased_disc_pixel_coverage regression: fail");
    $finish;
  end

  initial begin
    int               ph, k, cx_pix, span, px, py;
    logic [CRD_W-1:0] cx, cy;
    logic [RADIUS_W-1:0] rad;
    logic [COLOR_W-1:0]  color;
    logic [FA_W-1:0]     fa;

    pix_if.valid   = 1'b0;
    pix_if.pixel_x = '0;
    pix_if.pixel_y = '0;

    disc_cfg.center_x   = CRD_W'(512);
    disc_cfg.center_y   = CRD_W'(512);
    disc_cfg.radius     = '0;
    disc_cfg.draw_color = '0;
    disc_cfg.fill_alpha = ALPHA_ONE;
    disc_cfg.blend_mode = 1'b1;

    dir_tab = '{
      hit_row(0, 0, 0, 0, 0),
      hit_row(63, 63, 0, 0, 0),
      hit_row(0, 63, 0, 0, 0),
      hit_row(32, 32, 0, 0, 0),
      cfg_row(REG_RADIUS, 1023),
      cfg_row(REG_DRAW_COLOR, 32'hFFFFFF),
      hit_row(32, 32, 'hFFFFFF, 255, 1),
      hit_row(63, 63, 'hFFFFFF, 255, 1),
      hit_row(0, 0, 'hFFFFFF, 255, 1),
      cfg_row(REG_FILL_ALPHA, 300),
      hit_row(32, 32, 'hFFFFFF, 255, 1),
      cfg_row(REG_FILL_ALPHA, 0),
      hit_row(32, 32, 'hFFFFFF, 0, 0),
      cfg_row(REG_FILL_ALPHA, 511),
      hit_row(31, 31, 'hFFFFFF, 255, 1),
      cfg_row(REG_BLEND_MODE, 0),
      cfg_row(REG_FILL_ALPHA, 128),
      hit_row(32, 32, 'hFFFFFF, 255, 1),
      cfg_row(REG_FILL_ALPHA, 127),
      hit_row(32, 32, 'hFFFFFF, 0, 0),
      cfg_row(REG_RADIUS, 8),
      cfg_row(REG_FILL_ALPHA, 256),
      cfg_row(REG_BLEND_MODE, 1),
      cfg_row(REG_DRAW_COLOR, 32'h5A3C96),
      pix_row(32, 32),
      pix_row(33, 32),
      pix_row(31, 32),
      cfg_row(REG_BLEND_MODE, 0),
      pix_row(32, 32),
      cfg_row(REG_RADIUS, 13),
      pix_row(32, 32),
      cfg_row(REG_CENTER_X, 32'h800),
      cfg_row(REG_CENTER_Y, 32'h7FF),
      cfg_row(REG_RADIUS, 0),
      cfg_row(REG_BLEND_MODE, 1),
      pix_row(0, 63),
      cfg_row(REG_RADIUS, 1023),
      pix_row(0, 63),
      cfg_row(REG_CENTER_X, 0),
      cfg_row(REG_CENTER_Y, 0),
      pix_row(0, 0),
      pix_row(63, 63),
      pix_row(44, 44),
      pix_row(45, 45)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
        n_settings++;
      end else begin
        send_pixel(dir_tab[i]);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      quiet = (ph == N_PHASES - 1);
      case ($urandom_range(0, 2))
        0: src_gap_pct = 0;
        1: src_gap_pct = 15;
        default: src_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: sink_gap_pct = 0;
        1: sink_gap_pct = 15;
        default: sink_gap_pct = 40;
      endcase

      if (ph == 1) cx = 12'h800;
      else if (ph == 2) cx = 12'h7FF;
      else if ($urandom_range(0, 3) == 0) cx = CRD_W'($urandom);
      else cx = CRD_W'($urandom_range(0, 1023));
      if (ph == 2) cy = 12'h800;
      else if (ph == 1) cy = 12'h7FF;
      else if ($urandom_range(0, 3) == 0) cy = CRD_W'($urandom);
      else cy = CRD_W'($urandom_range(0, 1023));
      if (ph == 3) rad = '0;
      else if (ph == 4) rad = '1;
      else if ($urandom_range(0, 3) == 0) rad = RADIUS_W'($urandom);
      else rad = RADIUS_W'($urandom_range(0, 400));
      if (ph == 5) color = '0;
      else if (ph == 6) color = '1;
      else color = COLOR_W'($urandom);
      case ($urandom_range(0, 8))
        0: fa = FA_W'(0);
        1: fa = FA_W'(1);
        2: fa = FA_W'(127);
        3: fa = FA_W'(128);
        4: fa = FA_W'(255);
        5: fa = FA_W'(256);
        6: fa = FA_W'(257);
        7: fa = FA_W'(511);
        default: fa = FA_W'($urandom);
      endcase

      write_reg(REG_CENTER_X, DATA_W'(cx));
      write_reg(REG_CENTER_Y, DATA_W'(cy));
      write_reg(REG_RADIUS, DATA_W'(rad));
      write_reg(REG_DRAW_COLOR, DATA_W'(color));
      write_reg(REG_FILL_ALPHA, DATA_W'(fa));
      write_reg(REG_BLEND_MODE, DATA_W'($urandom_range(0, 1)));
      n_settings++;

      cx_pix = int'($signed(cx)) >>> SUB_BITS;
      span = int'(rad) / 16 + 2;
      for (k = 0; k < PHASE_LEN; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          // around the rim
          px = cx_pix + int'($urandom_range(0, 2 * span)) - span;
          py = (int'($signed(cy)) >>> SUB_BITS) + int'($urandom_range(0, 2 * span)) - span;
          if (px < 0) px = 0;
          if (px > 63) px = 63;
          if (py < 0) py = 0;
          if (py > 63) py = 63;
        end else begin
          px = $urandom_range(0, 63);
          py = $urandom_range(0, 63);
        end
        send_pixel(pix_row(px, py));
      end
    end

    pix_if.valid <= 1'b0;
    while (coverage_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d pixel requests under %0d disc settings, both sides stalling at random",
             n_items, n_settings);
    $display("%0d pixels drawn, %0d with partial coverage", n_drawn, n_partial);
    if (n_errors == 0 && coverage_due.size() == 0) begin
      $display("antialiased_disc_pixel_coverage regression: pass");
    end else begin
      $display("antialiased_disc_pixel_coverage regression: fail");
    end
    $finish;
  end

endmodule
